>>> hdl/srcp_pkg.sv
// ----------------------------------------------------------------------------
// srcp_pkg
// shared types and constants of the serial register command parser
// ----------------------------------------------------------------------------
`default_nettype none

package srcp_pkg;

  localparam int NUM_REGS_DEF    = 16;
  localparam int QUEUE_DEPTH_DEF = 16;

  localparam logic [15:0] RATE_CODE_RST = 16'd1152;

  // finished command from the parser
  typedef struct packed {
    logic        vld;
    logic        is_write;
    logic [7:0]  addr;
    logic [15:0] value;
  } enq_t;

  // command queue entry
  typedef struct packed {
    logic       is_write;
    logic [7:0] addr;
  } qent_t;

endpackage

`default_nettype wire

>>> hdl/srcp_channels.sv
// ----------------------------------------------------------------------------
// srcp channels
// valid/ready channels of the command parser: input, result, configuration
// ----------------------------------------------------------------------------
`default_nettype none

interface srcp_in_if;
  logic       valid;
  logic       ready;
  logic       cmd;
  logic [7:0] rx_byte;
  modport source (output valid, cmd, rx_byte, input ready);
  modport sink   (input valid, cmd, rx_byte, output ready);
endinterface

interface srcp_out_if;
  logic        valid;
  logic        ready;
  logic [7:0]  reg_index;
  logic [15:0] reg_value;
  logic        was_write;
  logic        rate_update;
  logic        addr_error;
  modport source (output valid, reg_index, reg_value, was_write, rate_update, addr_error,
                  input ready);
  modport sink   (input valid, reg_index, reg_value, was_write, rate_update, addr_error,
                  output ready);
endinterface

interface srcp_cfg_if;
  logic        valid;
  logic        ready;
  logic [15:0] default_rate_code;
  modport source (output valid, default_rate_code, input ready);
  modport sink   (input valid, default_rate_code, output ready);
endinterface

`default_nettype wire

>>> hdl/serial_register_command_parser_core.sv
// ----------------------------------------------------------------------------
// serial_register_command_parser_core
// ascii register command parser with command queue and shadow/live registers
// ----------------------------------------------------------------------------
// Takes one input transfer per cycle: a received byte (cmd 0) or a service
// request (cmd 1). Bytes are parsed in the cycle they are taken; a finished
// command enters the queue, if not full, in that same cycle, and a write to a
// valid address also writes the shadow register file. A service request on a
// non-empty queue gives its result transfer through queue ram read, register
// file read and result register. Consecutive service requests stream at one
// per cycle, a live register written by one pop being forwarded to the next.
// in_ready drops only while the result register and the register file stage
// are both held by a stalled result. Configuration transfers are always taken.
`default_nettype none

module serial_register_command_parser_core #(
  parameter int NUM_REGS    = srcp_pkg::NUM_REGS_DEF,
  parameter int QUEUE_DEPTH = srcp_pkg::QUEUE_DEPTH_DEF
) (
  input  wire logic   clk,
  input  wire logic   rst_n,
  srcp_in_if.sink     in_ch,
  srcp_out_if.source  out_ch,
  srcp_cfg_if.sink    cfg_ch
);

  import srcp_pkg::*;

  localparam int QAW  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNTW = $clog2(QUEUE_DEPTH + 1);

  logic            advance, in_acc, pop_go, enq_go, s1_vld_r;
  logic [QAW-1:0]  head_r, head_nxt, tail_r, tail_nxt;
  logic [CNTW-1:0] count_r, count_nxt;
  enq_t            enq;
  qent_t           q_wdata, q_rdata;

  assign in_ch.ready  = advance;
  assign cfg_ch.ready = 1'b1;
  assign in_acc       = in_ch.valid && advance;

  srcp_parser u_parser (
    .clk      (clk),
    .rst_n    (rst_n),
    .byte_vld (in_acc && !in_ch.cmd),
    .rx_byte  (in_ch.rx_byte),
    .enq      (enq)
  );

  assign pop_go = in_acc && in_ch.cmd && (count_r != '0);
  assign enq_go = enq.vld && (count_r < CNTW'(QUEUE_DEPTH));

  assign q_wdata.is_write = enq.is_write;
  assign q_wdata.addr     = enq.addr;

  srcp_ram #(.WIDTH($bits(qent_t)), .DEPTH(QUEUE_DEPTH)) u_queue (
    .clk   (clk),
    .we    (enq_go),
    .waddr (tail_r),
    .wdata (q_wdata),
    .re    (advance),
    .raddr (head_r),
    .rdata (q_rdata)
  );

  always_comb begin
    head_nxt  = head_r;
    tail_nxt  = tail_r;
    count_nxt = count_r;
    if (pop_go) begin
      head_nxt  = (head_r == QAW'(QUEUE_DEPTH - 1)) ? '0 : head_r + 1'b1;
      count_nxt = count_r - 1'b1;
    end
    if (enq_go) begin
      tail_nxt  = (tail_r == QAW'(QUEUE_DEPTH - 1)) ? '0 : tail_r + 1'b1;
      count_nxt = count_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r   <= '0;
      tail_r   <= '0;
      count_r  <= '0;
      s1_vld_r <= 1'b0;
    end else begin
      head_r  <= head_nxt;
      tail_r  <= tail_nxt;
      count_r <= count_nxt;
      if (advance) begin
        s1_vld_r <= pop_go;
      end
    end
  end

  srcp_service #(.NUM_REGS(NUM_REGS)) u_service (
    .clk      (clk),
    .rst_n    (rst_n),
    .s1_vld   (s1_vld_r),
    .s1_ent   (q_rdata),
    .enq      (enq),
    .cfg_wr   (cfg_ch.valid),
    .cfg_data (cfg_ch.default_rate_code),
    .advance  (advance),
    .out_ch   (out_ch)
  );

endmodule

`default_nettype wire

>>> hdl/srcp_ram.sv
// ----------------------------------------------------------------------------
// srcp_ram
// generic single write port ram with registered read, read before write
// ----------------------------------------------------------------------------
`default_nettype none

module srcp_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 16,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             re,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

>>> hdl/srcp_parser.sv
// ----------------------------------------------------------------------------
// srcp_parser
// byte level command parser with address and value accumulators
// ----------------------------------------------------------------------------
`default_nettype none

module srcp_parser (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          byte_vld,
  input  wire logic [7:0]    rx_byte,
  output srcp_pkg::enq_t     enq
);

  import srcp_pkg::*;

  localparam logic [2:0] PH_IDLE = 3'd0;
  localparam logic [2:0] PH_ADDR = 3'd1;
  localparam logic [2:0] PH_EQ   = 3'd2;
  localparam logic [2:0] PH_DEC  = 3'd3;
  localparam logic [2:0] PH_HEX  = 3'd4;

  localparam logic [7:0] CH_LBRACK = 8'h5B;
  localparam logic [7:0] CH_RBRACK = 8'h5D;
  localparam logic [7:0] CH_EQ     = 8'h3D;
  localparam logic [7:0] CH_QUERY  = 8'h3F;
  localparam logic [7:0] CH_DOT    = 8'h2E;
  localparam logic [7:0] CH_0      = 8'h30;
  localparam logic [7:0] CH_9      = 8'h39;
  localparam logic [7:0] CH_UA     = 8'h41;
  localparam logic [7:0] CH_UF     = 8'h46;
  localparam logic [7:0] CH_LA     = 8'h61;
  localparam logic [7:0] CH_LF     = 8'h66;
  localparam logic [7:0] CH_UX     = 8'h58;
  localparam logic [7:0] CH_LX     = 8'h78;

  logic [2:0]  phase_r, phase_nxt;
  logic [7:0]  addr_r, addr_nxt;
  logic [15:0] val_r, val_nxt;
  logic        is_dec, is_hexl;
  logic [3:0]  nib;

  always_comb begin
    is_dec  = rx_byte inside {[CH_0:CH_9]};
    is_hexl = rx_byte inside {[CH_UA:CH_UF], [CH_LA:CH_LF]};
    nib     = is_hexl ? (rx_byte[3:0] + 4'd9) : rx_byte[3:0];
  end

  always_comb begin
    phase_nxt    = phase_r;
    addr_nxt     = addr_r;
    val_nxt      = val_r;
    enq.vld      = 1'b0;
    enq.is_write = 1'b0;
    enq.addr     = addr_r;
    enq.value    = val_r;
    if (byte_vld) begin
      case (phase_r)
        PH_ADDR: begin
          if (rx_byte == CH_RBRACK) begin
            phase_nxt = PH_EQ;
          end else if (is_dec) begin
            addr_nxt = 8'(addr_r * 8'd10) + {4'd0, rx_byte[3:0]};
          end else if (rx_byte == CH_LBRACK) begin
            phase_nxt = PH_ADDR;
            addr_nxt  = '0;
          end else begin
            phase_nxt = PH_IDLE;
          end
        end
        PH_EQ: begin
          if (rx_byte == CH_EQ) begin
            phase_nxt = PH_DEC;
            val_nxt   = '0;
          end else if (rx_byte == CH_LBRACK) begin
            phase_nxt = PH_ADDR;
            addr_nxt  = '0;
          end else begin
            phase_nxt = PH_IDLE;
          end
        end
        PH_DEC: begin
          if (rx_byte == CH_QUERY) begin
            enq.vld   = 1'b1;
            phase_nxt = PH_IDLE;
          end else if (rx_byte == CH_LBRACK) begin
            phase_nxt = PH_ADDR;
            addr_nxt  = '0;
          end else if (rx_byte == CH_LX || rx_byte == CH_UX) begin
            phase_nxt = PH_HEX;
            val_nxt   = '0;
          end else if (is_dec) begin
            val_nxt = 16'(val_r * 16'd10) + {12'd0, rx_byte[3:0]};
          end else if (rx_byte == CH_DOT) begin
            enq.vld      = 1'b1;
            enq.is_write = 1'b1;
            phase_nxt    = PH_IDLE;
          end else begin
            phase_nxt = PH_IDLE;
          end
        end
        PH_HEX: begin
          if (rx_byte == CH_QUERY) begin
            enq.vld   = 1'b1;
            phase_nxt = PH_IDLE;
          end else if (rx_byte == CH_LBRACK) begin
            phase_nxt = PH_ADDR;
            addr_nxt  = '0;
          end else if (is_dec || is_hexl) begin
            val_nxt = {val_r[11:0], nib};
          end else if (rx_byte == CH_DOT) begin
            enq.vld      = 1'b1;
            enq.is_write = 1'b1;
            phase_nxt    = PH_IDLE;
          end else begin
            phase_nxt = PH_IDLE;
          end
        end
        default: begin
          if (rx_byte == CH_LBRACK) begin
            phase_nxt = PH_ADDR;
            addr_nxt  = '0;
          end else begin
            phase_nxt = PH_IDLE;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      addr_r  <= '0;
      val_r   <= '0;
    end else begin
      phase_r <= phase_nxt;
      addr_r  <= addr_nxt;
      val_r   <= val_nxt;
    end
  end

endmodule

`default_nettype wire

>>> hdl/srcp_service.sv
// ----------------------------------------------------------------------------
// srcp_service
// shadow and live register files and the service pipeline with result register
// ----------------------------------------------------------------------------
`default_nettype none

module srcp_service #(
  parameter int NUM_REGS = srcp_pkg::NUM_REGS_DEF
) (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            s1_vld,
  input  wire srcp_pkg::qent_t s1_ent,
  input  wire srcp_pkg::enq_t  enq,
  input  wire logic            cfg_wr,
  input  wire logic [15:0]     cfg_data,
  output logic                 advance,
  srcp_out_if.source           out_ch
);

  import srcp_pkg::*;

  localparam int IDXW = (NUM_REGS > 1) ? $clog2(NUM_REGS) : 1;

  logic [15:0]         rate_code_r;
  logic [NUM_REGS-1:0] sh_vld_r, lv_vld_r;

  logic            s2_vld_r, s2_wr_r, s2_ok_r, s2_shv_r, s2_lvv_r, s2_fwd_r;
  logic [7:0]      s2_addr_r;
  logic [15:0]     s2_fwd_val_r;
  logic [IDXW-1:0] s2_idx, s1_idx, enq_idx;
  logic            s1_ok, enq_ok, sh_we, lv_we, s2_leave, fwd;
  logic [15:0]     sh_rd, lv_rd, sh_val, lv_base, lv_val, s2_val;

  logic        out_vld_r;
  logic [7:0]  out_idx_r;
  logic [15:0] out_val_r;
  logic        out_wr_r, out_rate_r, out_err_r;

  assign s1_ok   = {1'b0, s1_ent.addr} < 9'(NUM_REGS);
  assign s1_idx  = s1_ent.addr[IDXW-1:0];
  assign enq_ok  = {1'b0, enq.addr} < 9'(NUM_REGS);
  assign enq_idx = enq.addr[IDXW-1:0];
  assign s2_idx  = s2_addr_r[IDXW-1:0];

  assign advance  = !s2_vld_r || !out_vld_r || out_ch.ready;
  assign s2_leave = s2_vld_r && advance;
  assign sh_we    = enq.vld && enq.is_write && enq_ok;
  assign lv_we    = s2_leave && s2_wr_r && s2_ok_r;
  assign fwd      = s2_vld_r && s2_wr_r && s2_ok_r && (s2_idx == s1_idx);

  srcp_ram #(.WIDTH(16), .DEPTH(NUM_REGS)) u_shadow (
    .clk   (clk),
    .we    (sh_we),
    .waddr (enq_idx),
    .wdata (enq.value),
    .re    (advance),
    .raddr (s1_idx),
    .rdata (sh_rd)
  );

  srcp_ram #(.WIDTH(16), .DEPTH(NUM_REGS)) u_live (
    .clk   (clk),
    .we    (lv_we),
    .waddr (s2_idx),
    .wdata (s2_val),
    .re    (advance),
    .raddr (s1_idx),
    .rdata (lv_rd)
  );

  always_comb begin
    sh_val  = s2_shv_r ? sh_rd : '0;
    lv_base = s2_lvv_r ? lv_rd : ((s2_idx == '0) ? rate_code_r : '0);
    lv_val  = s2_fwd_r ? s2_fwd_val_r : lv_base;
    if (!s2_ok_r) begin
      s2_val = '0;
    end else if (s2_wr_r) begin
      s2_val = sh_val;
    end else begin
      s2_val = lv_val;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rate_code_r <= RATE_CODE_RST;
      sh_vld_r    <= '0;
      lv_vld_r    <= '0;
      s2_vld_r    <= 1'b0;
      out_vld_r   <= 1'b0;
    end else begin
      if (cfg_wr) begin
        rate_code_r <= cfg_data;
        lv_vld_r[0] <= 1'b0;
      end
      if (sh_we) begin
        sh_vld_r[enq_idx] <= 1'b1;
      end
      if (lv_we) begin
        lv_vld_r[s2_idx] <= 1'b1;
      end
      if (advance) begin
        s2_vld_r <= s1_vld;
      end
      if (s2_leave) begin
        out_vld_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  // stage two payload, read data valid flags, forwarded live write and result register
  always_ff @(posedge clk) begin
    if (advance) begin
      s2_addr_r    <= s1_ent.addr;
      s2_wr_r      <= s1_ent.is_write;
      s2_ok_r      <= s1_ok;
      s2_shv_r     <= sh_vld_r[s1_idx];
      s2_lvv_r     <= lv_vld_r[s1_idx];
      s2_fwd_r     <= fwd;
      s2_fwd_val_r <= s2_val;
    end
    if (s2_leave) begin
      out_idx_r  <= s2_addr_r;
      out_val_r  <= s2_val;
      out_wr_r   <= s2_wr_r;
      out_rate_r <= s2_wr_r && s2_ok_r && (s2_idx == '0);
      out_err_r  <= !s2_ok_r;
    end
  end

  assign out_ch.valid       = out_vld_r;
  assign out_ch.reg_index   = out_idx_r;
  assign out_ch.reg_value   = out_val_r;
  assign out_ch.was_write   = out_wr_r;
  assign out_ch.rate_update = out_rate_r;
  assign out_ch.addr_error  = out_err_r;

endmodule

`default_nettype wire

>>> hdl/srcp_checker.sv
// ----------------------------------------------------------------------------
// srcp_checker
// port level checks of the command parser result channel
// ----------------------------------------------------------------------------
`default_nettype none

module srcp_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [7:0]  reg_index,
  input wire logic [15:0] reg_value,
  input wire logic        was_write,
  input wire logic        rate_update,
  input wire logic        addr_error
);

  // stalled result transfer holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(reg_index) && $stable(reg_value)
      && $stable(was_write) && $stable(rate_update) && $stable(addr_error))
    else $error("result changed while stalled");

  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && addr_error |-> reg_value == 16'd0 && !rate_update)
    else $error("bad address result not cleared");

  a_rate_reg0: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && rate_update |-> was_write && reg_index == 8'd0 && !addr_error)
    else $error("rate update without write to register zero");

  a_rst_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind serial_register_command_parser_core srcp_checker u_srcp_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .out_valid   (out_ch.valid),
  .out_ready   (out_ch.ready),
  .reg_index   (out_ch.reg_index),
  .reg_value   (out_ch.reg_value),
  .was_write   (out_ch.was_write),
  .rate_update (out_ch.rate_update),
  .addr_error  (out_ch.addr_error)
);

`default_nettype wire
